// ===== rtl/core/dhqp_pkg.sv =====
// Shared types and constants for the DNS header and question parser.
// Used by every module in rtl/core; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package dhqp_pkg;

   localparam int NameCapacityDefault = 256;

   localparam int HeaderBytes    = 12;
   localparam int HeaderWords    = 6;
   localparam int TypeClassBytes = 4;

   localparam logic [7:0] CompressMask = 8'hC0;
   localparam logic [7:0] DotChar      = 8'h2E;

   localparam int ReqDataWidth = 8;
   localparam int RspDataWidth = 152;

   typedef enum logic [2:0] {
      PH_HEADER     = 3'd0,
      PH_LABEL_LEN  = 3'd1,
      PH_LABEL_DATA = 3'd2,
      PH_TYPE_CLASS = 3'd3,
      PH_DONE       = 3'd4,
      PH_ERROR      = 3'd5
   } phase_type;

   localparam logic [2:0] ST_OK          = 3'd0;
   localparam logic [2:0] ST_SHORT_HDR   = 3'd1;
   localparam logic [2:0] ST_COMPRESSED  = 3'd2;
   localparam logic [2:0] ST_NAME_LONG   = 3'd3;
   localparam logic [2:0] ST_TRUNC_NAME  = 3'd4;
   localparam logic [2:0] ST_TRUNC_TYPE  = 3'd5;

   localparam logic KIND_CHAR    = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   typedef struct packed {
      logic        kind;
      logic [7:0]  name_char;
      logic [7:0]  name_length;
      logic [15:0] ident;
      logic [15:0] flag_word;
      logic [15:0] question_count;
      logic [15:0] answer_count;
      logic [15:0] authority_count;
      logic [15:0] additional_count;
      logic [15:0] query_type;
      logic [15:0] query_class;
      logic [2:0]  status;
   } rsp_item_type;

endpackage

`default_nettype wire

// ===== rtl/core/dhqp_parse_core.sv =====
// Parser state machine: header gather, name label decode and type/class gather.
// Produces at most one result item per accepted byte. Depends on dhqp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dhqp_parse_core #(
   parameter int NAME_CAPACITY = dhqp_pkg::NameCapacityDefault
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 beat_valid,
   input  wire logic [7:0]           data_byte,
   input  wire logic                 end_of_packet,
   output logic                      result_valid,
   output dhqp_pkg::rsp_item_type    result
);
   import dhqp_pkg::*;

   localparam logic [9:0] CapLimit = 10'(NAME_CAPACITY);

   phase_type   phase_ff, phase_in;
   logic [3:0]  field_cnt_ff, field_cnt_in;
   logic [15:0] header_words_ff [HeaderWords];
   logic [15:0] header_words_in [HeaderWords];
   logic [5:0]  label_rem_ff, label_rem_in;
   logic [7:0]  name_cnt_ff, name_cnt_in;
   logic [15:0] tc_words_ff [2];
   logic [15:0] tc_words_in [2];
   logic [2:0]  error_ff, error_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HEADER;
         field_cnt_ff <= '0;
         label_rem_ff <= '0;
         name_cnt_ff  <= '0;
         error_ff     <= '0;
         for (int i = 0; i < HeaderWords; i++) begin
            header_words_ff[i] <= '0;
         end
         tc_words_ff[0] <= '0;
         tc_words_ff[1] <= '0;
      end else if (beat_valid) begin
         phase_ff     <= phase_in;
         field_cnt_ff <= field_cnt_in;
         label_rem_ff <= label_rem_in;
         name_cnt_ff  <= name_cnt_in;
         error_ff     <= error_in;
         for (int i = 0; i < HeaderWords; i++) begin
            header_words_ff[i] <= header_words_in[i];
         end
         tc_words_ff[0] <= tc_words_in[0];
         tc_words_ff[1] <= tc_words_in[1];
      end
   end

   always_comb begin
      logic        emit_char;
      logic [7:0]  char_val;
      logic [2:0]  hw_idx;
      logic [9:0]  need;
      logic [2:0]  st;

      phase_in     = phase_ff;
      field_cnt_in = field_cnt_ff;
      label_rem_in = label_rem_ff;
      name_cnt_in  = name_cnt_ff;
      error_in     = error_ff;
      for (int i = 0; i < HeaderWords; i++) begin
         header_words_in[i] = header_words_ff[i];
      end
      tc_words_in[0] = tc_words_ff[0];
      tc_words_in[1] = tc_words_ff[1];
      emit_char = 1'b0;
      char_val  = '0;
      hw_idx    = field_cnt_ff[3:1];
      need      = {2'b00, name_cnt_ff} + {9'd0, (name_cnt_ff != 8'd0)}
                  + {2'b00, data_byte} + 10'd1;
      st        = ST_OK;
      result    = '0;

      case (phase_ff)
         PH_HEADER: begin
            if (field_cnt_ff[0] == 1'b0) begin
               header_words_in[hw_idx][15:8] = data_byte;
            end else begin
               header_words_in[hw_idx][7:0] = data_byte;
            end
            field_cnt_in = field_cnt_ff + 4'd1;
            if (field_cnt_ff == 4'(HeaderBytes - 1)) begin
               field_cnt_in = '0;
               phase_in = (header_words_in[2] != 16'd0) ? PH_LABEL_LEN : PH_DONE;
            end
         end
         PH_LABEL_LEN: begin
            if (data_byte == 8'd0) begin
               phase_in     = PH_TYPE_CLASS;
               field_cnt_in = '0;
            end else if ((data_byte & CompressMask) != 8'd0) begin
               phase_in = PH_ERROR;
               error_in = ST_COMPRESSED;
            end else if (need > CapLimit) begin
               phase_in = PH_ERROR;
               error_in = ST_NAME_LONG;
            end else begin
               label_rem_in = data_byte[5:0];
               phase_in     = PH_LABEL_DATA;
               // A dot separates this label from the previous one.
               if (name_cnt_ff != 8'd0) begin
                  name_cnt_in = name_cnt_ff + 8'd1;
                  emit_char   = 1'b1;
                  char_val    = DotChar;
               end
            end
         end
         PH_LABEL_DATA: begin
            name_cnt_in = name_cnt_ff + 8'd1;
            emit_char   = 1'b1;
            char_val    = data_byte;
            if (label_rem_ff != 6'd0) begin
               label_rem_in = label_rem_ff - 6'd1;
            end
            if (label_rem_in == 6'd0) begin
               phase_in = PH_LABEL_LEN;
            end
         end
         PH_TYPE_CLASS: begin
            if (field_cnt_ff[0] == 1'b0) begin
               tc_words_in[field_cnt_ff[1]][15:8] = data_byte;
            end else begin
               tc_words_in[field_cnt_ff[1]][7:0] = data_byte;
            end
            field_cnt_in = field_cnt_ff + 4'd1;
            if (field_cnt_ff == 4'(TypeClassBytes - 1)) begin
               field_cnt_in = '0;
               phase_in     = PH_DONE;
            end
         end
         default: begin
         end
      endcase

      case (phase_in)
         PH_ERROR:                    st = error_in;
         PH_HEADER:                   st = ST_SHORT_HDR;
         PH_LABEL_LEN, PH_LABEL_DATA: st = ST_TRUNC_NAME;
         PH_TYPE_CLASS:               st = ST_TRUNC_TYPE;
         default:                     st = ST_OK;
      endcase

      if (end_of_packet) begin
         result.kind   = KIND_SUMMARY;
         result.status = st;
         if (st != ST_SHORT_HDR) begin
            result.ident            = header_words_in[0];
            result.flag_word        = header_words_in[1];
            result.question_count   = header_words_in[2];
            result.answer_count     = header_words_in[3];
            result.authority_count  = header_words_in[4];
            result.additional_count = header_words_in[5];
         end
         if (st == ST_OK) begin
            result.name_length = name_cnt_in;
            if (header_words_in[2] != 16'd0) begin
               result.query_type  = tc_words_in[0];
               result.query_class = tc_words_in[1];
            end
         end
         // The packet is finished: return to the reset state.
         phase_in     = PH_HEADER;
         field_cnt_in = '0;
         label_rem_in = '0;
         name_cnt_in  = '0;
         error_in     = '0;
         for (int i = 0; i < HeaderWords; i++) begin
            header_words_in[i] = '0;
         end
         tc_words_in[0] = '0;
         tc_words_in[1] = '0;
      end else begin
         result.kind        = KIND_CHAR;
         result.name_char   = char_val;
         result.name_length = name_cnt_in;
      end

      result_valid = beat_valid && (end_of_packet || emit_char);
   end

endmodule

`default_nettype wire

// ===== rtl/core/dhqp_out_skid.sv =====
// Result register with a one-entry skid stage, so input beats keep flowing
// while a finished result waits. Depends on dhqp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dhqp_out_skid (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push_valid,
   input  dhqp_pkg::rsp_item_type    push_item,
   output logic                      push_ready,
   output logic                      out_valid,
   output dhqp_pkg::rsp_item_type    out_item,
   input  wire logic                 out_ready
);
   import dhqp_pkg::*;

   logic         main_valid_ff, main_valid_in;
   logic         skid_valid_ff, skid_valid_in;
   rsp_item_type main_item_ff, main_item_in;
   rsp_item_type skid_item_ff, skid_item_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_item_ff <= main_item_in;
      skid_item_ff <= skid_item_in;
   end

   always_comb begin
      logic pop;
      pop           = main_valid_ff && out_ready;
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_item_in  = main_item_ff;
      skid_item_in  = skid_item_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            main_item_in  = skid_item_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push_valid) begin
         if (!main_valid_ff || pop) begin
            main_item_in  = push_item;
            main_valid_in = 1'b1;
         end else begin
            skid_item_in  = push_item;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         main_valid_in = 1'b0;
      end
   end

   assign push_ready = !skid_valid_ff;
   assign out_valid  = main_valid_ff;
   assign out_item   = main_item_ff;

endmodule

`default_nettype wire

// ===== rtl/core/dns_header_question_parser_unit.sv =====
// DNS header and first-question parser, one packet byte per beat.
// Output path: each result beat is registered in the main result stage, or in the skid stage while the output stalls.
// Throughput: one input beat per cycle; the skid stage holds one extra result,
// so input stalls only when two results wait on a stalled output.
// Reset: synchronous, active high; clears the parser to the header phase and
// empties the result stages. Depends on dhqp_pkg, dhqp_parse_core, dhqp_out_skid.
`timescale 1ns / 1ps
`default_nettype none

module dns_header_question_parser_unit #(
   parameter int NAME_CAPACITY = dhqp_pkg::NameCapacityDefault
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   input  wire logic [dhqp_pkg::ReqDataWidth-1:0]  req_tdata,  // [7:0] data_byte
   input  wire logic                               req_tlast,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // [7:0] name_char, [15:8] name_length, [31:16] ident, [47:32] flag_word,
   // [63:48] question_count, [79:64] answer_count, [95:80] authority_count,
   // [111:96] additional_count, [127:112] query_type, [143:128] query_class,
   // [146:144] status, [151:147] zero
   output logic [dhqp_pkg::RspDataWidth-1:0]       rsp_tdata,
   output logic                                    rsp_tuser   // [0] kind
);
   import dhqp_pkg::*;

   logic         beat_accept;
   logic         result_valid;
   rsp_item_type result;
   rsp_item_type out_item;

   assign beat_accept = req_tvalid && req_tready;

   dhqp_parse_core #(
      .NAME_CAPACITY(NAME_CAPACITY)
   ) u_core (
      .clock        (clock),
      .reset        (reset),
      .beat_valid   (beat_accept),
      .data_byte    (req_tdata[7:0]),
      .end_of_packet(req_tlast),
      .result_valid (result_valid),
      .result       (result)
   );

   dhqp_out_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .push_valid(result_valid),
      .push_item (result),
      .push_ready(req_tready),
      .out_valid (rsp_tvalid),
      .out_item  (out_item),
      .out_ready (rsp_tready)
   );

   assign rsp_tuser = out_item.kind;
   assign rsp_tdata = {5'd0, out_item.status, out_item.query_class, out_item.query_type,
                       out_item.additional_count, out_item.authority_count,
                       out_item.answer_count, out_item.question_count,
                       out_item.flag_word, out_item.ident,
                       out_item.name_length, out_item.name_char};

   // The input side stalls only when both result stages are full.
   a_stall_needs_result: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("input stalled with no result waiting");

   // The final byte of a packet always yields a summary beat.
   a_last_gives_result: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tlast) |=> rsp_tvalid)
      else $error("no result after last byte");

   // Character beats carry a nonzero running length and a clean status.
   a_char_beat_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == KIND_CHAR) |->
         (rsp_tdata[146:144] == ST_OK && rsp_tdata[15:8] != 8'd0))
      else $error("malformed character beat");

   // A short header summary reports no header words.
   a_short_hdr_clear: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == KIND_SUMMARY && rsp_tdata[146:144] == ST_SHORT_HDR)
         |-> (rsp_tdata[143:16] == '0))
      else $error("short header summary carries header data");

endmodule

`default_nettype wire

// ===== dv/tb_dns_header_question_parser_unit.sv =====
// Self-checking testbench for the DNS header and first-question parser.
// Drives packet bytes with random gaps and back-pressure, predicts each result beat
// in a scoreboard class and compares field by field. Depends on dhqp_pkg and the RTL.
`timescale 1ns / 1ps

module tb_dns_header_question_parser_unit;

   import dhqp_pkg::*;

   localparam int IdleLimit  = 500;
   localparam int RandomBytes = 300;

   class dns_parse_scoreboard;
      phase_type    parse_phase;
      logic [3:0]   byte_idx;
      logic [15:0]  hdr_word [6];
      logic [5:0]   label_left;
      logic [7:0]   name_len;
      logic [15:0]  qtc_word [2];
      logic [2:0]   err_status;
      rsp_item_type expected_beats [$];
      int           mismatches;
      int           beat_no;

      function new();
         mismatches = 0;
         beat_no    = 0;
         clear_state();
      endfunction

      function void clear_state();
         parse_phase = PH_HEADER;
         byte_idx    = '0;
         foreach (hdr_word[i]) hdr_word[i] = '0;
         label_left  = '0;
         name_len    = '0;
         qtc_word[0] = '0;
         qtc_word[1] = '0;
         err_status  = ST_OK;
      endfunction

      function int pending();
         return expected_beats.size();
      endfunction

      // Advances the parser by one accepted byte and queues the beat it causes, if any.
      function void parse_byte(logic [7:0] b, logic last);
         rsp_item_type res;
         logic         emit;
         logic [7:0]   ch;
         logic [2:0]   st;
         int           dot;
         emit = 1'b0;
         ch   = '0;
         case (parse_phase)
            PH_HEADER: begin
               if (!byte_idx[0]) hdr_word[byte_idx[3:1]][15:8] = b;
               else hdr_word[byte_idx[3:1]][7:0] = b;
               byte_idx++;
               if (byte_idx >= HeaderBytes) begin
                  byte_idx    = '0;
                  parse_phase = (hdr_word[2] != 16'd0) ? PH_LABEL_LEN : PH_DONE;
               end
            end
            PH_LABEL_LEN: begin
               if (b == 8'd0) begin
                  parse_phase = PH_TYPE_CLASS;
                  byte_idx    = '0;
               end else if ((b & CompressMask) != 8'd0) begin
                  err_status  = ST_COMPRESSED;
                  parse_phase = PH_ERROR;
               end else begin
                  dot = (name_len != 8'd0) ? 1 : 0;
                  // One slot is kept back for the terminator.
                  if (int'(name_len) + dot + int'(b) + 1 > NameCapacityDefault) begin
                     err_status  = ST_NAME_LONG;
                     parse_phase = PH_ERROR;
                  end else begin
                     label_left  = b[5:0];
                     parse_phase = PH_LABEL_DATA;
                     if (dot != 0) begin
                        name_len++;
                        emit = 1'b1;
                        ch   = DotChar;
                     end
                  end
               end
            end
            PH_LABEL_DATA: begin
               name_len++;
               emit = 1'b1;
               ch   = b;
               if (label_left != 6'd0) label_left--;
               if (label_left == 6'd0) parse_phase = PH_LABEL_LEN;
            end
            PH_TYPE_CLASS: begin
               if (!byte_idx[0]) qtc_word[byte_idx[1]][15:8] = b;
               else qtc_word[byte_idx[1]][7:0] = b;
               byte_idx++;
               if (byte_idx >= TypeClassBytes) begin
                  byte_idx    = '0;
                  parse_phase = PH_DONE;
               end
            end
            default: ;
         endcase

         res = '0;
         if (last) begin
            if (parse_phase == PH_ERROR) st = err_status;
            else if (parse_phase == PH_HEADER) st = ST_SHORT_HDR;
            else if (parse_phase == PH_LABEL_LEN || parse_phase == PH_LABEL_DATA)
               st = ST_TRUNC_NAME;
            else if (parse_phase == PH_TYPE_CLASS) st = ST_TRUNC_TYPE;
            else st = ST_OK;
            res.kind = KIND_SUMMARY;
            if (st != ST_SHORT_HDR) begin
               res.ident            = hdr_word[0];
               res.flag_word        = hdr_word[1];
               res.question_count   = hdr_word[2];
               res.answer_count     = hdr_word[3];
               res.authority_count  = hdr_word[4];
               res.additional_count = hdr_word[5];
            end
            if (st == ST_OK) begin
               res.name_length = name_len;
               if (hdr_word[2] != 16'd0) begin
                  res.query_type  = qtc_word[0];
                  res.query_class = qtc_word[1];
               end
            end
            res.status = st;
            expected_beats.push_back(res);
            clear_state();
         end else if (emit) begin
            res.kind        = KIND_CHAR;
            res.name_char   = ch;
            res.name_length = name_len;
            expected_beats.push_back(res);
         end
      endfunction

      task report(string msg);
         $display("ERROR: %s", msg);
         mismatches++;
      endtask

      task compare_field(string what, logic [15:0] got, logic [15:0] want);
         if (got !== want)
            report($sformatf("result beat %0d: %s is %h, expected %h",
                             beat_no, what, got, want));
      endtask

      task check_beat(logic [RspDataWidth-1:0] d, logic kind);
         rsp_item_type want;
         beat_no++;
         if (expected_beats.size() == 0) begin
            report($sformatf("result beat %0d arrived with nothing expected", beat_no));
            return;
         end
         want = expected_beats.pop_front();
         compare_field("kind", 16'(kind), 16'(want.kind));
         compare_field("name_char", 16'(d[7:0]), 16'(want.name_char));
         compare_field("name_length", 16'(d[15:8]), 16'(want.name_length));
         compare_field("ident", d[31:16], want.ident);
         compare_field("flag_word", d[47:32], want.flag_word);
         compare_field("question_count", d[63:48], want.question_count);
         compare_field("answer_count", d[79:64], want.answer_count);
         compare_field("authority_count", d[95:80], want.authority_count);
         compare_field("additional_count", d[111:96], want.additional_count);
         compare_field("query_type", d[127:112], want.query_type);
         compare_field("query_class", d[143:128], want.query_class);
         compare_field("status", 16'(d[146:144]), 16'(want.status));
         compare_field("padding", 16'(d[151:147]), 16'd0);
      endtask
   endclass

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [ReqDataWidth-1:0] req_tdata = '0;
   logic                    req_tlast = 1'b0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RspDataWidth-1:0] rsp_tdata;
   logic                    rsp_tuser;

   dns_parse_scoreboard sb = new();
   logic [7:0] pkt [$];
   int         len_at [$];
   int         bytes_sent = 0;
   int         send_quiet = 0;
   int         recv_quiet = 0;
   int         idle_cycles = 0;

   dns_header_question_parser_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #2 clock = ~clock;

   // A side occasionally enters a quiet stretch in which it never waits.
   function automatic int draw_wait(inout int quiet);
      if (quiet == 0 && $urandom_range(0, 9) == 0) quiet = $urandom_range(10, 40);
      if (quiet > 0) begin
         quiet--;
         return 0;
      end
      return $urandom_range(0, 17);
   endfunction

   task send_byte(logic [7:0] b, logic last);
      int gap;
      gap = draw_wait(send_quiet);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.parse_byte(b, last);
      bytes_sent++;
   endtask

   // Always advances the clock before it checks, so valid is never dropped and raised in one step.
   task drain_expected();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   task send_packet();
      for (int i = 0; i < pkt.size(); i++) send_byte(pkt[i], i == pkt.size() - 1);
      pkt.delete();
      len_at.delete();
   endtask

   task put_word(logic [15:0] w);
      pkt.push_back(w[15:8]);
      pkt.push_back(w[7:0]);
   endtask

   task put_header(logic [15:0] qd);
      put_word(16'($urandom));
      put_word(16'($urandom));
      put_word(qd);
      repeat (3) put_word(16'($urandom));
   endtask

   task put_label(int n);
      len_at.push_back(pkt.size());
      pkt.push_back(8'(n));
      repeat (n) pkt.push_back(8'($urandom));
   endtask

   task build_random_packet();
      int roll;
      int n;
      int cut;
      int pos;
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
         n = $urandom_range(1, 20);
         repeat (n) pkt.push_back(8'($urandom));
      end else if (roll < 14) begin
         put_header(16'd0);
         repeat ($urandom_range(0, 4)) pkt.push_back(8'($urandom));
      end else begin
         put_header(roll < 30 ? 16'd1 : 16'($urandom_range(1, 65535)));
         // Rarely a name of big labels that may run into the capacity limit.
         if (roll < 16) repeat ($urandom_range(3, 6)) put_label($urandom_range(40, 63));
         else repeat ($urandom_range(0, 4)) put_label($urandom_range(1, 12));
         pkt.push_back(8'h00);
         put_word(16'($urandom));
         put_word(16'($urandom));
         repeat ($urandom_range(0, 3)) pkt.push_back(8'($urandom));
         roll = $urandom_range(0, 99);
         if (roll < 15) begin
            cut = $urandom_range(1, pkt.size());
            while (pkt.size() > cut) void'(pkt.pop_back());
         end else if (roll < 25 && len_at.size() > 0) begin
            pos = len_at[$urandom_range(0, len_at.size() - 1)];
            pkt[pos] = pkt[pos] | (8'($urandom_range(1, 3)) << 6);
         end
      end
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IdleLimit) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   initial begin
      int stall;
      while (reset) @(posedge clock);
      forever begin
         stall = draw_wait(recv_quiet);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         sb.check_beat(rsp_tdata, rsp_tuser);
      end
   end

   initial begin
      int random_start;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // One byte only, then a header one byte short.
      pkt.push_back(8'hFF);
      send_packet();
      repeat (11) pkt.push_back(8'hFF);
      send_packet();
      // All-zero header: no question, so the packet is complete.
      repeat (12) pkt.push_back(8'h00);
      send_packet();
      // All-ones header with an empty root name and trailing bytes.
      repeat (12) pkt.push_back(8'hFF);
      pkt.push_back(8'h00);
      repeat (4) pkt.push_back(8'hFF);
      pkt.push_back(8'h00);
      pkt.push_back(8'hFF);
      send_packet();
      // Three labels, extreme character values, well formed.
      put_header(16'd1);
      put_label(1);
      pkt.push_back(8'd2);
      pkt.push_back(8'h00);
      pkt.push_back(8'hFF);
      put_label(3);
      pkt.push_back(8'h00);
      put_word(16'd1);
      put_word(16'd1);
      send_packet();
      // Compression pointers in each form, with bytes after the error ignored.
      put_header(16'd1);
      pkt.push_back(8'hC0);
      pkt.push_back(8'h01);
      pkt.push_back(8'h41);
      send_packet();
      put_header(16'd2);
      put_label(2);
      pkt.push_back(8'h40);
      pkt.push_back(8'h00);
      send_packet();
      put_header(16'd3);
      put_label(1);
      put_label(1);
      pkt.push_back(8'h80);
      send_packet();
      // Packets that end in the name, on the terminator and inside the type.
      put_header(16'd1);
      send_packet();
      put_header(16'd1);
      put_label(1);
      put_label(2);
      send_packet();
      put_header(16'd1);
      put_label(4);
      pkt.push_back(8'h00);
      send_packet();
      put_header(16'd1);
      put_label(1);
      pkt.push_back(8'h00);
      put_word(16'h1234);
      send_packet();
      // Four full labels reach 255 characters; the next label is refused.
      put_header(16'd1);
      repeat (4) put_label(63);
      put_label(1);
      pkt.push_back(8'h00);
      put_word(16'($urandom));
      put_word(16'($urandom));
      send_packet();
      drain_expected();

      random_start = bytes_sent;
      while (bytes_sent - random_start < RandomBytes) begin
         build_random_packet();
         send_packet();
         if ($urandom_range(0, 19) == 0) drain_expected();
      end
      drain_expected();
      repeat (8) @(posedge clock);

      if (sb.mismatches == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

endmodule

// ===== dns_header_question_parser_unit.f =====
rtl/core/dhqp_pkg.sv
rtl/core/dhqp_parse_core.sv
rtl/core/dhqp_out_skid.sv
rtl/core/dns_header_question_parser_unit.sv
dv/tb_dns_header_question_parser_unit.sv
